>>> src/mfdt_pkg.sv
// Shared types and constants for the minifloat to decimal text core.
// Used by mfdt_ucode_rom, mfdt_datapath and minifloat_to_decimal_text_core.
`default_nettype none
package mfdt_pkg;

   localparam int unsigned PcWidth   = 4;
   localparam int unsigned CharWidth = 7;

   typedef logic [PcWidth-1:0]   pc_type;
   typedef logic [CharWidth-1:0] char_type;

   // program entry points
   localparam pc_type STEP_MINUS = 4'd0;
   localparam pc_type STEP_TENS  = 4'd1;

   localparam char_type CHAR_MINUS = 7'h2D;
   localparam char_type CHAR_DOT   = 7'h2E;
   localparam char_type CHAR_ZERO  = 7'h30;

   // character source selected by one control word
   typedef enum logic [2:0] {
      SRC_MINUS,
      SRC_TENS,
      SRC_ONES,
      SRC_DOT,
      SRC_FRAC
   } src_type;

   typedef struct packed {
      src_type src;
      logic    last;
   } ucode_type;

   // control from the sequencer to the datapath
   typedef struct packed {
      logic    load;
      logic    step;
      src_type src;
   } ctl_type;

endpackage
`default_nettype wire

>>> src/mfdt_ucode_rom.sv
// Microcode table: one control word per program step.
// Depends on mfdt_pkg.
`default_nettype none
module mfdt_ucode_rom (
   input  mfdt_pkg::pc_type    pc,
   output mfdt_pkg::ucode_type word
);

   always_comb begin
      case (pc)
         4'd0:    word = '{src: mfdt_pkg::SRC_MINUS, last: 1'b0};
         4'd1:    word = '{src: mfdt_pkg::SRC_TENS,  last: 1'b0};
         4'd2:    word = '{src: mfdt_pkg::SRC_ONES,  last: 1'b0};
         4'd3:    word = '{src: mfdt_pkg::SRC_DOT,   last: 1'b0};
         4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10:
                  word = '{src: mfdt_pkg::SRC_FRAC,  last: 1'b0};
         4'd11:   word = '{src: mfdt_pkg::SRC_FRAC,  last: 1'b1};
         default: word = '{src: mfdt_pkg::SRC_FRAC,  last: 1'b1};
      endcase
   end

endmodule
`default_nettype wire

>>> src/mfdt_datapath.sv
// Datapath: unpacks the minifloat into integer and fraction registers and
// forms one ASCII character per step. Depends on mfdt_pkg.
`default_nettype none
module mfdt_datapath (
   input  wire                   clock,
   input  mfdt_pkg::ctl_type     ctl,
   input  wire  [7:0]            packed_value,
   output mfdt_pkg::char_type    text_char
);

   logic [3:0]  whole_ff, whole_in;
   logic [7:0]  frac_ff, frac_in;
   logic [7:0]  mant;
   logic [3:0]  shamt;
   logic [15:0] field;
   logic [11:0] frac_x10;
   logic        ge_ten;
   logic [3:0]  ones;

   assign mant     = {1'b1, packed_value[6:3], 3'b000};
   assign shamt    = 4'd11 - {1'b0, packed_value[2:0]};
   assign field    = {mant, 8'h00} >> shamt;
   // next fraction digit: times ten, the carry out of the byte is the digit
   assign frac_x10 = {1'b0, frac_ff, 3'b000} + {3'b000, frac_ff, 1'b0};
   assign ge_ten   = (whole_ff >= 4'd10);
   assign ones     = ge_ten ? (whole_ff - 4'd10) : whole_ff;

   always_comb begin
      whole_in = whole_ff;
      frac_in  = frac_ff;
      if (ctl.load) begin
         whole_in = field[11:8];
         frac_in  = field[7:0];
      end else if (ctl.step && ctl.src == mfdt_pkg::SRC_FRAC) begin
         frac_in = frac_x10[7:0];
      end
   end

   always_ff @(posedge clock) begin
      whole_ff <= whole_in;
      frac_ff  <= frac_in;
   end

   always_comb begin
      case (ctl.src)
         mfdt_pkg::SRC_MINUS: text_char = mfdt_pkg::CHAR_MINUS;
         mfdt_pkg::SRC_TENS:  text_char = mfdt_pkg::CHAR_ZERO + {6'd0, ge_ten};
         mfdt_pkg::SRC_ONES:  text_char = mfdt_pkg::CHAR_ZERO + {3'd0, ones};
         mfdt_pkg::SRC_DOT:   text_char = mfdt_pkg::CHAR_DOT;
         mfdt_pkg::SRC_FRAC:  text_char = mfdt_pkg::CHAR_ZERO + {3'd0, frac_x10[11:8]};
         default:             text_char = mfdt_pkg::CHAR_ZERO;
      endcase
   end

endmodule
`default_nettype wire

>>> src/minifloat_to_decimal_text_core.sv
// Minifloat to decimal text: microcoded sequencer, one character per step.
// Accept loads the item; each step registers one character, stalling while
// the output register is full. A negative item runs the twelve-step program,
// a positive one skips the sign step; the next is taken with the last step.
// Reset (synchronous) idles the sequencer and empties the output register.
// Depends on mfdt_pkg, mfdt_ucode_rom and mfdt_datapath.
`default_nettype none
module minifloat_to_decimal_text_core (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_tvalid,
   output logic       req_tready,
   input  wire  [7:0] req_tdata,   // [7:0] packed_value
   output logic       rsp_tvalid,
   input  wire        rsp_tready,
   output logic [7:0] rsp_tdata,   // [6:0] text_char, [7] zero
   output logic       rsp_tlast    // is_last
);

   logic                busy_ff, busy_in;
   mfdt_pkg::pc_type    pc_ff, pc_in;
   logic                out_valid_ff, out_valid_in;
   mfdt_pkg::char_type  out_char_ff, out_char_in;
   logic                out_last_ff, out_last_in;
   mfdt_pkg::ucode_type word;
   mfdt_pkg::ctl_type   ctl;
   mfdt_pkg::char_type  text_char;
   logic                step;
   logic                accept;

   mfdt_ucode_rom u_rom (
      .pc   (pc_ff),
      .word (word)
   );

   mfdt_datapath u_dp (
      .clock        (clock),
      .ctl          (ctl),
      .packed_value (req_tdata),
      .text_char    (text_char)
   );

   assign step       = busy_ff && (!out_valid_ff || rsp_tready);
   // hold off new items while in reset
   assign req_tready = !reset && (!busy_ff || (step && word.last));
   assign accept     = req_tvalid && req_tready;
   assign ctl        = '{load: accept, step: step, src: word.src};

   always_comb begin
      busy_in      = busy_ff;
      pc_in        = pc_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      if (step) begin
         out_valid_in = 1'b1;
         out_char_in  = text_char;
         out_last_in  = word.last;
         pc_in        = pc_ff + 4'd1;
         if (word.last) begin
            busy_in = 1'b0;
         end
      end
      // dispatch: skip the sign step for a positive value
      if (accept) begin
         busy_in = 1'b1;
         pc_in   = req_tdata[7] ? mfdt_pkg::STEP_MINUS : mfdt_pkg::STEP_TENS;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pc_ff        <= mfdt_pkg::STEP_MINUS;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         pc_ff        <= pc_in;
         out_valid_ff <= out_valid_in;
      end
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_char_ff};
   assign rsp_tlast  = out_last_ff;

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy_ff)
      else $error("accepted item did not start the sequencer");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (step && word.last && !accept) |=> !busy_ff)
      else $error("sequencer kept running after the last step");

   a_pc_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (pc_ff <= 4'd11))
      else $error("step counter ran past the program");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_tready) |=> !$past(step))
      else $error("character overwritten before it was taken");

endmodule
`default_nettype wire
